// ----- src/psg_pkg.sv -----
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and lookup tables of the three-channel sound
// generator: register masks, the volume table and the sequencer states.
// ----------------------------------------------------------------------------
package psg_pkg;

    // Block sizes.
    localparam int CHANNELS  = 3;
    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int MAX_OUT   = 32;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);

    // Field widths.
    localparam int TONE_W   = 12;
    localparam int NOISE_W  = 5;
    localparam int LFSR_W   = 17;
    localparam int TACC_W   = 18;
    localparam int SACC_W   = 26;
    localparam int PROD_W   = 22;
    localparam int MAG_W    = 17;

    // Mixer constants: fixed envelope level and the 0.33 scale in Q0.16.
    localparam logic [15:0] ENV_LEVEL  = 16'd24576;
    localparam logic [14:0] SCALE_Q16  = 15'd21627;
    localparam logic [32:0] ROUND_HALF = 33'd32768;

    // Configuration register defaults.
    localparam logic [15:0] TONE_DIV_RESET  = 16'd16;
    localparam logic [15:0] STEP_RESET      = 16'd16;
    localparam logic [23:0] PERIOD_RESET    = 24'd1270;

    // Register file addresses with special meaning.
    localparam int NOISE_REG  = 6;
    localparam int ENABLE_REG = 7;
    localparam int AMP_REG    = 8;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TONE_DIV      = 2'd0,
        CFG_SAMPLE_STEP   = 2'd1,
        CFG_SAMPLE_PERIOD = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_idx_t;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_TSUB  = 9'b000000010,
        ST_TLOOP = 9'b000000100,
        ST_PROD  = 9'b000001000,
        ST_SSUB  = 9'b000010000,
        ST_MIX   = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_SLOOP = 9'b010000000,
        ST_RDOUT = 9'b100000000
    } state_t;

    // Settings that the tone and noise generator reads from the register file.
    typedef struct packed {
        logic [CHANNELS-1:0][TONE_W-1:0] period;
        logic [CHANNELS-1:0]             amp_nz;
        logic [NOISE_W-1:0]              noise_per;
    } gen_cfg_t;

    // Levels that the generator hands to the mixer.
    typedef struct packed {
        logic [CHANNELS-1:0] tone_level;
        logic                lfsr_bit;
    } gen_stat_t;

    // Write mask of each register.
    function automatic logic [7:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
        logic [7:0] m;
        case (idx)
            4'd1, 4'd3, 4'd5, 4'd13:    m = 8'h0F;
            4'd6, 4'd8, 4'd9, 4'd10:    m = 8'h1F;
            default:                    m = 8'hFF;
        endcase
        return m;
    endfunction

    // Logarithmic channel volume in Q1.15.
    function automatic logic [15:0] vol_lookup(input logic [3:0] code);
        logic [15:0] v;
        case (code)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd328;
            4'd2:    v = 16'd474;
            4'd3:    v = 16'd690;
            4'd4:    v = 16'd1006;
            4'd5:    v = 16'd1493;
            4'd6:    v = 16'd2114;
            4'd7:    v = 16'd3518;
            4'd8:    v = 16'd4148;
            4'd9:    v = 16'd6717;
            4'd10:   v = 16'd9575;
            4'd11:   v = 16'd12217;
            4'd12:   v = 16'd16139;
            4'd13:   v = 16'd20818;
            4'd14:   v = 16'd26397;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

// ----- src/psg_gen.sv -----
// ----------------------------------------------------------------------------
// psg_gen
// Tone and noise generator: per-channel 12-bit tone counters, the 5-bit
// noise counter and the 17-bit noise LFSR, advanced by one tick per strobe.
// ----------------------------------------------------------------------------
module psg_gen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  psg_pkg::gen_cfg_t    cfg,
    output psg_pkg::gen_stat_t   stat
);
    import psg_pkg::*;

    logic [CHANNELS-1:0][TONE_W-1:0] tone_count_reg;
    logic [CHANNELS-1:0][TONE_W-1:0] tone_count_next;
    logic [CHANNELS-1:0]             tone_level_reg;
    logic [CHANNELS-1:0]             tone_level_next;
    logic [NOISE_W-1:0]              noise_count_reg;
    logic [NOISE_W-1:0]              noise_count_next;
    logic                            noise_level_reg;
    logic                            noise_level_next;
    logic [LFSR_W-1:0]               noise_shift_reg;
    logic [LFSR_W-1:0]               noise_shift_next;

    // One tick of every tone lane and of the noise counter.
    always_comb
    begin
        logic [TONE_W-1:0]  cnt1;
        logic [TONE_W-1:0]  per;
        logic [NOISE_W-1:0] ncnt1;
        logic [NOISE_W-1:0] nper;
        tone_count_next  = tone_count_reg;
        tone_level_next  = tone_level_reg;
        noise_count_next = noise_count_reg;
        noise_level_next = noise_level_reg;
        noise_shift_next = noise_shift_reg;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            cnt1 = tone_count_reg[ch] + 1'b1;
            per  = (cfg.period[ch] == '0) ? TONE_W'(1) : cfg.period[ch];
            if (cfg.amp_nz[ch])
            begin
                if (cnt1 >= per)
                begin
                    tone_count_next[ch] = '0;
                    tone_level_next[ch] = ~tone_level_reg[ch];
                end
                else
                begin
                    tone_count_next[ch] = cnt1;
                end
            end
            else
            begin
                tone_level_next[ch] = 1'b0;
            end
        end
        ncnt1 = noise_count_reg + 1'b1;
        nper  = (cfg.noise_per == '0) ? NOISE_W'(1) : cfg.noise_per;
        if (ncnt1 >= nper)
        begin
            noise_count_next = '0;
            noise_level_next = ~noise_level_reg;
            // The LFSR shifts on each rising noise level.
            if (!noise_level_reg)
            begin
                noise_shift_next = {noise_shift_reg[0] ^ noise_shift_reg[3],
                                    noise_shift_reg[LFSR_W-1:1]};
            end
        end
        else
        begin
            noise_count_next = ncnt1;
        end
    end

    // Generator state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_count_reg  <= '0;
            tone_level_reg  <= '0;
            noise_count_reg <= '0;
            noise_level_reg <= 1'b0;
            noise_shift_reg <= LFSR_W'(1);
        end
        else if (tick)
        begin
            tone_count_reg  <= tone_count_next;
            tone_level_reg  <= tone_level_next;
            noise_count_reg <= noise_count_next;
            noise_level_reg <= noise_level_next;
            noise_shift_reg <= noise_shift_next;
        end
    end

    assign stat.tone_level = tone_level_reg;
    assign stat.lfsr_bit   = noise_shift_reg[0];

endmodule

// ----- src/psg_tone_noise_mixer.sv -----
// ----------------------------------------------------------------------------
// psg_tone_noise_mixer
// Three-channel sound generator with a masked register file, tone and noise
// generators and a sample mixer, run by a small sequencer around one shared
// 26-bit accumulator adder.
// ----------------------------------------------------------------------------
// A write takes effect at its accept edge; a read word is loaded into the output
// register from RDOUT after its accept, and the input stalls until then. A tick
// word stalls the input through TSUB, TLOOP (one adder pass per tone tick), PROD,
// SSUB, MIX and, when a sample is due, SCALE and SLOOP (one adder pass per due
// sample); output stalls lengthen it while a word waits for the output register.
// Reset (asynchronous, active low) clears the control state and loads the defaults.
module psg_tone_noise_mixer (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [5:0]  cycle_count,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_sample,
    output logic signed [15:0] sample,
    output logic [7:0]  read_data,
    output logic        last,
    // Configuration channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import psg_pkg::*;

    // Sequencer and configuration.
    state_t                    state_reg, state_next;
    logic [15:0]               tone_div_reg;
    logic [15:0]               step_reg;
    logic [23:0]               period_reg;
    logic [7:0]                reg_file_reg [REG_COUNT];

    // Working registers.
    logic signed [TACC_W-1:0]  tick_accum_reg;
    logic signed [SACC_W-1:0]  sample_accum_reg;
    logic [5:0]                cyc_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [15:0]               smp_reg;
    logic [7:0]                rd_data_reg;
    logic [CNT_W-1:0]          emit_cnt_reg;

    // Output register.
    logic                      out_valid_reg;
    logic                      out_is_sample_reg;
    logic [15:0]               out_sample_reg;
    logic [7:0]                out_read_reg;
    logic                      out_last_reg;

    // Handshake and control decodes.
    logic                      in_accept;
    logic                      cfg_write;
    logic                      out_free;
    logic                      emit_smp;
    logic                      emit_rd;
    logic                      emit_last;
    logic                      gen_tick;
    logic                      tick_le0;
    logic                      sample_le0;
    logic                      add_le0;

    // Shared adder.
    logic signed [SACC_W-1:0]  add_a;
    logic signed [SACC_W-1:0]  add_b;
    logic signed [SACC_W-1:0]  add_sum;

    logic [15:0]               div_eff;
    logic [23:0]               per_eff;
    logic [23:0]               per_max;

    // Mixer.
    logic signed [MAG_W:0]     mix_sum;
    logic [32:0]               scale_prod;
    logic [MAG_W-1:0]          q_mag;
    logic [15:0]               q_sat;

    gen_cfg_t                  gen_cfg;
    gen_stat_t                 gen_stat;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;

    // Effective divider and sample period.
    assign div_eff = (tone_div_reg == '0) ? 16'd1 : tone_div_reg;
    assign per_max = (period_reg < {8'd0, step_reg}) ? {8'd0, step_reg} : period_reg;
    assign per_eff = (per_max == '0) ? 24'd1 : per_max;

    assign tick_le0   = tick_accum_reg[TACC_W-1] || (tick_accum_reg == '0);
    assign sample_le0 = sample_accum_reg[SACC_W-1] || (sample_accum_reg == '0);

    // Operand selection for the shared accumulator adder.
    always_comb
    begin
        add_a = sample_accum_reg;
        add_b = SACC_W'($signed({1'b0, per_eff}));
        case (state_reg)
            ST_TSUB:
            begin
                add_a = SACC_W'(tick_accum_reg);
                add_b = SACC_W'(0) - SACC_W'(cyc_reg);
            end
            ST_TLOOP:
            begin
                add_a = SACC_W'(tick_accum_reg);
                add_b = SACC_W'(div_eff);
            end
            ST_SSUB:
            begin
                add_b = SACC_W'(0) - SACC_W'(prod_reg);
            end
            default:
            begin
                add_b = SACC_W'(per_eff);
            end
        endcase
    end

    assign add_sum = add_a + add_b;
    assign add_le0 = add_sum[SACC_W-1] || (add_sum == '0);

    // Generator settings taken from the register file.
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            gen_cfg.period[ch] = {reg_file_reg[2*ch+1][3:0], reg_file_reg[2*ch]};
            gen_cfg.amp_nz[ch] = (reg_file_reg[AMP_REG+ch][3:0] != 4'd0);
        end
        gen_cfg.noise_per = reg_file_reg[NOISE_REG][NOISE_W-1:0];
    end

    assign gen_tick = (state_reg == ST_TLOOP) && tick_le0;

    psg_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (gen_tick),
        .cfg   (gen_cfg),
        .stat  (gen_stat)
    );

    // Mix plus or minus each channel volume.
    always_comb
    begin
        logic [7:0]  amp;
        logic [15:0] vol;
        logic        tone_ok;
        logic        noise_ok;
        mix_sum = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            amp      = reg_file_reg[AMP_REG+ch];
            vol      = amp[4] ? ENV_LEVEL : vol_lookup(amp[3:0]);
            tone_ok  = gen_stat.tone_level[ch] | reg_file_reg[ENABLE_REG][ch];
            noise_ok = gen_stat.lfsr_bit | reg_file_reg[ENABLE_REG][ch+3];
            if (tone_ok && noise_ok)
            begin
                mix_sum = mix_sum + (MAG_W+1)'(vol);
            end
            else
            begin
                mix_sum = mix_sum - (MAG_W+1)'(vol);
            end
        end
    end

    // Scale by 0.33, round half away from zero, saturate.
    assign scale_prod = 33'(mag_reg) * 33'(SCALE_Q16) + ROUND_HALF;
    assign q_mag      = scale_prod[32:16];
    always_comb
    begin
        if (!neg_reg)
        begin
            q_sat = (q_mag > MAG_W'(32767)) ? 16'h7FFF : q_mag[15:0];
        end
        else
        begin
            q_sat = (q_mag > MAG_W'(32768)) ? 16'h8000 : (16'd0 - q_mag[15:0]);
        end
    end

    // Result emission.
    assign emit_smp  = (state_reg == ST_SLOOP) && sample_le0 &&
                       (emit_cnt_reg < CNT_W'(MAX_OUT)) && out_free;
    assign emit_rd   = (state_reg == ST_RDOUT) && out_free;
    assign emit_last = !add_le0 || (emit_cnt_reg == CNT_W'(MAX_OUT - 1));

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && command == CMD_TICK)
                begin
                    state_next = ST_TSUB;
                end
                else if (in_accept && command == CMD_READ)
                begin
                    state_next = ST_RDOUT;
                end
            end
            ST_TSUB:  state_next = ST_TLOOP;
            ST_TLOOP:
            begin
                if (!tick_le0)
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:  state_next = ST_SSUB;
            ST_SSUB:  state_next = ST_MIX;
            ST_MIX:   state_next = sample_le0 ? ST_SCALE : ST_IDLE;
            ST_SCALE: state_next = ST_SLOOP;
            ST_SLOOP:
            begin
                if (!sample_le0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RDOUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control registers, configuration and register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tone_div_reg     <= TONE_DIV_RESET;
            step_reg         <= STEP_RESET;
            period_reg       <= PERIOD_RESET;
            tick_accum_reg   <= TACC_W'(TONE_DIV_RESET);
            sample_accum_reg <= '0;
            emit_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                reg_file_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TONE_DIV:    tone_div_reg <= cfg_data[15:0];
                    CFG_SAMPLE_STEP: step_reg     <= cfg_data[15:0];
                    CFG_SAMPLE_PERIOD:
                    begin
                        period_reg <= (cfg_data < {8'd0, step_reg}) ?
                                      {8'd0, step_reg} : cfg_data;
                    end
                    default:         ;
                endcase
            end

            // Register file writes.
            if (in_accept && command == CMD_WRITE &&
                reg_index < 8'(REG_COUNT))
            begin
                reg_file_reg[reg_index[REG_IDX_W-1:0]] <=
                    write_data & reg_mask(reg_index[REG_IDX_W-1:0]);
            end

            // Accumulators through the shared adder.
            if (state_reg == ST_TSUB || gen_tick)
            begin
                tick_accum_reg <= add_sum[TACC_W-1:0];
            end
            if (state_reg == ST_SSUB ||
                (state_reg == ST_SLOOP && sample_le0 &&
                 (emit_cnt_reg >= CNT_W'(MAX_OUT) || out_free)))
            begin
                sample_accum_reg <= add_sum;
            end

            // Count of emitted samples.
            if (state_reg == ST_SCALE)
            begin
                emit_cnt_reg <= '0;
            end
            else if (emit_smp)
            begin
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
            end

            // Output word valid.
            if (emit_smp || emit_rd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cyc_reg     <= cycle_count;
            rd_data_reg <= (reg_index < 8'(REG_COUNT)) ?
                           reg_file_reg[reg_index[REG_IDX_W-1:0]] : 8'd0;
        end
        if (state_reg == ST_PROD)
        begin
            prod_reg <= PROD_W'(cyc_reg) * PROD_W'(step_reg);
        end
        if (state_reg == ST_MIX)
        begin
            neg_reg <= mix_sum[MAG_W];
            mag_reg <= mix_sum[MAG_W] ? MAG_W'(-mix_sum) : mix_sum[MAG_W-1:0];
        end
        if (state_reg == ST_SCALE)
        begin
            smp_reg <= q_sat;
        end
        if (emit_smp)
        begin
            out_is_sample_reg <= 1'b1;
            out_sample_reg    <= smp_reg;
            out_read_reg      <= 8'd0;
            out_last_reg      <= emit_last;
        end
        else if (emit_rd)
        begin
            out_is_sample_reg <= 1'b0;
            out_sample_reg    <= 16'd0;
            out_read_reg      <= rd_data_reg;
            out_last_reg      <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_sample = out_is_sample_reg;
    assign sample    = $signed(out_sample_reg);
    assign read_data = out_read_reg;
    assign last      = out_last_reg;

`ifndef SYNTHESIS
    // No more than the result limit is ever emitted for one word.
    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= CNT_W'(MAX_OUT))
        else $error("sample count beyond the result limit");

    // Tone ticks stop only once the tick accumulator is positive again.
    a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROD) |-> (tick_accum_reg > 0))
        else $error("tone tick loop left with a non-positive accumulator");

    // A read word always closes its input.
    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_is_sample_reg) |-> out_last_reg)
        else $error("read word without last");

    // An accepted tick word starts the tick sequence.
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_TICK) |=> (state_reg == ST_TSUB))
        else $error("tick word did not start the sequencer");
`endif

endmodule
